>>> hdl/c2s_pkg.sv
package c2s_pkg;

    localparam int DefStages     = 32;
    localparam int DefCoordWidth = 32;
    localparam int GuardBits     = 20;
    localparam int AtanEntries   = 40;
    // Internal datapath width: coordinate, guard bits and CORDIC growth.
    localparam int DataWidth     = 32 + GuardBits + 4;
    localparam int AngWidth      = 34;
    localparam logic [31:0] InvGainQ32 = 32'h9B74EDA8;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } c2s_in_t;

    typedef struct packed {
        logic [31:0]        radius;
        logic [31:0]        polar_angle;
        logic signed [31:0] azimuth;
        logic               zero_radius;
    } c2s_out_t;

    function automatic logic signed [AngWidth-1:0] atan_unit(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
                3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
                6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
                9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
                12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
                15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
                18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
                21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
                24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
                27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
                30: v = 32'h00000001;
                default: v = 32'h0;
            endcase
            atan_unit = AngWidth'(signed'({1'b0, v}));
        end
    endfunction

endpackage

>>> hdl/c2s_cell.sv
// One CORDIC vectoring micro-rotation with its register. Side data rides along.
module c2s_cell #(
    parameter int Shift     = 0,
    parameter int SideWidth = 1
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [c2s_pkg::DataWidth-1:0]  a_in,
    input  logic signed [c2s_pkg::DataWidth-1:0]  b_in,
    input  logic signed [c2s_pkg::AngWidth-1:0]   ang_in,
    input  logic [SideWidth-1:0]                  side_in,
    output logic signed [c2s_pkg::DataWidth-1:0]  a_out,
    output logic signed [c2s_pkg::DataWidth-1:0]  b_out,
    output logic signed [c2s_pkg::AngWidth-1:0]   ang_out,
    output logic [SideWidth-1:0]                  side_out
);
    import c2s_pkg::*;

    logic signed [DataWidth-1:0] a_reg, a_next, b_reg, b_next;
    logic signed [AngWidth-1:0]  ang_reg, ang_next;
    logic [SideWidth-1:0]        side_reg;

    always_comb
    begin
        if (!b_in[DataWidth-1])
        begin
            a_next   = a_in + (b_in >>> Shift);
            b_next   = b_in - (a_in >>> Shift);
            ang_next = ang_in + atan_unit(Shift);
        end
        else
        begin
            a_next   = a_in - (b_in >>> Shift);
            b_next   = b_in + (a_in >>> Shift);
            ang_next = ang_in - atan_unit(Shift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            ang_reg  <= ang_next;
            side_reg <= side_in;
        end
    end

    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign ang_out  = ang_reg;
    assign side_out = side_reg;
endmodule

>>> hdl/c2s_gain.sv
// Two-stage gain compensation: floor(v * InvGainQ32 / 2^32) for nonnegative v.
module c2s_gain #(
    parameter int SideWidth = 1
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [c2s_pkg::DataWidth-1:0] v_in,
    input  logic [SideWidth-1:0]                 side_in,
    output logic [c2s_pkg::DataWidth-1:0]        v_out,
    output logic [SideWidth-1:0]                 side_out
);
    import c2s_pkg::*;

    localparam int HiW = DataWidth - 32;

    logic [HiW+31:0]  hi_reg, hi_next;
    logic [63:0]      lo_reg, lo_next;
    logic [DataWidth-1:0] v_reg;
    logic [SideWidth-1:0] s1_reg, s2_reg;

    // Split into a narrow high part and a 32-bit low part, one product each.
    assign hi_next = (HiW+32)'(v_in[DataWidth-1:32]) * (HiW+32)'(InvGainQ32);
    assign lo_next = 64'(v_in[31:0]) * 64'(InvGainQ32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            s1_reg <= side_in;
            v_reg  <= DataWidth'(hi_reg) + DataWidth'(lo_reg[63:32]);
            s2_reg <= s1_reg;
        end
    end

    assign v_out    = v_reg;
    assign side_out = s2_reg;
endmodule

>>> hdl/cartesian_to_spherical.sv
// Converts a stream of Cartesian points (x, y, z) to spherical form: the radius
// on the coordinate scale, the polar angle from +z and the azimuth, both as
// binary angles in which 2^31 stands for pi. The origin gives zeros and raises
// zero_radius. The block is a fully pipelined chain of CORDIC cells: one word is
// accepted every cycle unless the output stalls, and a word passes through the two
// vectoring chains (one cell per stage each), two two-stage gain multipliers and
// the entry, mid and output registers. The whole pipeline advances only when the
// output register is empty or being taken, so a stall on the output holds every
// word in place.
module cartesian_to_spherical #(
    parameter int CORDIC_STAGES = c2s_pkg::DefStages,
    parameter int COORD_WIDTH   = c2s_pkg::DefCoordWidth
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  c2s_pkg::c2s_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output c2s_pkg::c2s_out_t out_data
);
    import c2s_pkg::*;

    localparam int CoordBits = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int Latency   = 2 * CORDIC_STAGES + 7;
    // Side data carried with the first pass: z (scaled), z-axis and origin flags.
    localparam int Side1W    = DataWidth + 2;
    // Side data carried with the second pass: azimuth and origin flag.
    localparam int Side2W    = 33;

    logic adv;
    logic [Latency-1:0] vld_reg;

    // The pipeline moves when the output register is free or being emptied.
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Latency-2:0], in_valid};
    end
    assign out_valid = vld_reg[Latency-1];

    // Entry register: sign-extend the used bits and add guard bits.
    logic signed [DataWidth-1:0] x_s, y_s, z_s;
    logic signed [DataWidth-1:0] a0_reg, b0_reg, z0_reg;
    logic signed [AngWidth-1:0]  ang0_reg;
    logic                        zax0_reg, org0_reg;

    assign x_s = DataWidth'(signed'(in_data.coord_x[CoordBits-1:0])) <<< GuardBits;
    assign y_s = DataWidth'(signed'(in_data.coord_y[CoordBits-1:0])) <<< GuardBits;
    assign z_s = DataWidth'(signed'(in_data.coord_z[CoordBits-1:0])) <<< GuardBits;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Fold the left half-plane onto the right, starting at pi.
            if (x_s < 0)
            begin
                a0_reg   <= -x_s;
                b0_reg   <= -y_s;
                ang0_reg <= AngWidth'(64'sd1 <<< 31);
            end
            else
            begin
                a0_reg   <= x_s;
                b0_reg   <= y_s;
                ang0_reg <= '0;
            end
            z0_reg   <= z_s;
            zax0_reg <= (x_s == 0) && (y_s == 0);
            org0_reg <= (x_s == 0) && (y_s == 0) && (z_s == 0);
        end
    end

    // First vectoring chain on (x, y).
    logic signed [DataWidth-1:0] a1 [CORDIC_STAGES+1];
    logic signed [DataWidth-1:0] b1 [CORDIC_STAGES+1];
    logic signed [AngWidth-1:0]  g1 [CORDIC_STAGES+1];
    logic [Side1W-1:0]           s1 [CORDIC_STAGES+1];

    assign a1[0] = a0_reg;
    assign b1[0] = b0_reg;
    assign g1[0] = ang0_reg;
    assign s1[0] = {z0_reg, zax0_reg, org0_reg};

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_pass1
        c2s_cell #(.Shift(i), .SideWidth(Side1W)) u_cell (
            .clk(clk), .en(adv),
            .a_in(a1[i]), .b_in(b1[i]), .ang_in(g1[i]), .side_in(s1[i]),
            .a_out(a1[i+1]), .b_out(b1[i+1]), .ang_out(g1[i+1]), .side_out(s1[i+1])
        );
    end

    logic [DataWidth-1:0]  rho;
    logic [Side1W+31:0]    gs1_out;

    c2s_gain #(.SideWidth(Side1W + 32)) u_gain1 (
        .clk(clk), .en(adv),
        .v_in(a1[CORDIC_STAGES]),
        .side_in({s1[CORDIC_STAGES], g1[CORDIC_STAGES][31:0]}),
        .v_out(rho), .side_out(gs1_out)
    );

    // Mid register: set up (z, rho), rotating by pi/2 when z is negative.
    logic signed [DataWidth-1:0] zm, rhom;
    logic zaxm, orgm;
    logic [31:0] phim;
    logic signed [DataWidth-1:0] a2_reg, b2_reg;
    logic signed [AngWidth-1:0]  ang2_reg;
    logic [Side2W-1:0]           side2_reg;

    assign {zm, zaxm, orgm} = gs1_out[Side1W+31:32];
    assign phim = zaxm ? 32'd0 : gs1_out[31:0];
    assign rhom = zaxm ? '0 : signed'(rho);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (zm < 0)
            begin
                a2_reg   <= rhom;
                b2_reg   <= -zm;
                ang2_reg <= AngWidth'(64'sd1 <<< 30);
            end
            else
            begin
                a2_reg   <= zm;
                b2_reg   <= rhom;
                ang2_reg <= '0;
            end
            side2_reg <= {phim, orgm};
        end
    end

    // Second vectoring chain on (z, rho).
    logic signed [DataWidth-1:0] a2 [CORDIC_STAGES+1];
    logic signed [DataWidth-1:0] b2 [CORDIC_STAGES+1];
    logic signed [AngWidth-1:0]  g2 [CORDIC_STAGES+1];
    logic [Side2W-1:0]           s2 [CORDIC_STAGES+1];

    assign a2[0] = a2_reg;
    assign b2[0] = b2_reg;
    assign g2[0] = ang2_reg;
    assign s2[0] = side2_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_pass2
        c2s_cell #(.Shift(i), .SideWidth(Side2W)) u_cell (
            .clk(clk), .en(adv),
            .a_in(a2[i]), .b_in(b2[i]), .ang_in(g2[i]), .side_in(s2[i]),
            .a_out(a2[i+1]), .b_out(b2[i+1]), .ang_out(g2[i+1]), .side_out(s2[i+1])
        );
    end

    logic [DataWidth-1:0]         rad_full;
    logic [Side2W+AngWidth-1:0]   gs2_out;

    c2s_gain #(.SideWidth(Side2W + AngWidth)) u_gain2 (
        .clk(clk), .en(adv),
        .v_in(a2[CORDIC_STAGES]),
        .side_in({s2[CORDIC_STAGES], g2[CORDIC_STAGES]}),
        .v_out(rad_full), .side_out(gs2_out)
    );

    // Output register: clamp theta, saturate the radius, force the origin case.
    logic signed [AngWidth-1:0] theta;
    logic [31:0]                theta_c, phi_o;
    logic                       org_o;
    logic [DataWidth-GuardBits-1:0] rad_sh;
    logic [31:0]                rad_c;
    c2s_out_t                   out_reg;

    assign theta = gs2_out[AngWidth-1:0];
    assign {phi_o, org_o} = gs2_out[Side2W+AngWidth-1:AngWidth];
    assign rad_sh = rad_full[DataWidth-1:GuardBits];

    always_comb
    begin
        if (theta < 0)
            theta_c = '0;
        else if (theta > AngWidth'(64'sd1 <<< 31))
            theta_c = 32'h8000_0000;
        else
            theta_c = theta[31:0];
        rad_c = (rad_sh[DataWidth-GuardBits-1:32] != '0) ? 32'hFFFF_FFFF : rad_sh[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.radius      <= org_o ? 32'd0 : rad_c;
            out_reg.polar_angle <= org_o ? 32'd0 : theta_c;
            out_reg.azimuth     <= org_o ? 32'sd0 : signed'(phi_o);
            out_reg.zero_radius <= org_o;
        end
    end
    assign out_data = out_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result moved under stall");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_radius |-> out_data.radius == 32'd0)
        else $error("origin with nonzero radius");
    a_theta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.polar_angle <= 32'h8000_0000)
        else $error("polar angle out of range");
endmodule

>>> tb/sv/c2s_checker.sv
// Watches both channels of the converter, predicts each result word from the
// accepted input word and compares the two field by field.
module c2s_checker
    import c2s_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_stall,
    input  c2s_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_stall,
    input  c2s_out_t out_data,
    output int       errors,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumStages = 32;
    localparam int FracBits  = 20;
    localparam longint unsigned RecipGain = 64'h9B74EDA8;

    localparam longint AtanTbl [0:31] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001, 64'h0
    };

    c2s_out_t sph_expected [$];

    assign pending = sph_expected.size();

    function automatic void rotate_to_axis(inout longint a, inout longint b,
                                           inout longint ang);
        longint da;
        longint db;
        for (int i = 0; i < NumStages; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0)
            begin
                a = a + da; b = b - db; ang = ang + AtanTbl[i];
            end
            else
            begin
                a = a - da; b = b + db; ang = ang - AtanTbl[i];
            end
        end
    endfunction

    function automatic longint unsigned undo_gain(longint unsigned v);
        return (v >> 32) * RecipGain + (((v & 64'hFFFF_FFFF) * RecipGain) >> 32);
    endfunction

    function automatic c2s_out_t to_spherical(c2s_in_t p);
        c2s_out_t r;
        longint x, y, z, a, b, ang, rho, theta, t;
        longint unsigned len;
        x = p.coord_x; y = p.coord_y; z = p.coord_z;
        rho = 0;
        r = '0;
        if (x == 0 && y == 0 && z == 0)
        begin
            r.zero_radius = 1'b1;
            return r;
        end
        if (x != 0 || y != 0)
        begin
            a = x <<< FracBits; b = y <<< FracBits; ang = 0;
            if (a < 0)
            begin
                a = -a; b = -b; ang = 64'sd1 <<< 31;
            end
            rotate_to_axis(a, b, ang);
            r.azimuth = ang[31:0];
            rho = longint'(undo_gain(a));
        end
        a = z <<< FracBits; b = rho; ang = 0;
        if (a < 0)
        begin
            t = a; a = b; b = -t; ang = 64'sd1 <<< 30;
        end
        rotate_to_axis(a, b, ang);
        theta = ang;
        if (theta < 0)
            theta = 0;
        if (theta > (64'sd1 <<< 31))
            theta = 64'sd1 <<< 31;
        len = undo_gain(a) >> FracBits;
        if (len > 64'hFFFF_FFFF)
            len = 64'hFFFF_FFFF;
        r.radius      = len[31:0];
        r.polar_angle = theta[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        c2s_out_t want;
        if (!rst_n)
        begin
            errors = 0;
            sph_expected.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                sph_expected.push_back(to_spherical(in_data));
            if (out_valid && !out_stall)
            begin
                if (sph_expected.size() == 0)
                    report_mismatch("unexpected word", longint'(out_data.radius), 0);
                else
                begin
                    want = sph_expected.pop_front();
                    if (out_data.radius !== want.radius)
                        report_mismatch("radius", out_data.radius, want.radius);
                    if (out_data.polar_angle !== want.polar_angle)
                        report_mismatch("polar_angle", out_data.polar_angle,
                                        want.polar_angle);
                    if (out_data.azimuth !== want.azimuth)
                        report_mismatch("azimuth", out_data.azimuth, want.azimuth);
                    if (out_data.zero_radius !== want.zero_radius)
                        report_mismatch("zero_radius", out_data.zero_radius,
                                        want.zero_radius);
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Stimulus and verdict for the Cartesian to spherical converter. The checker
// beside the block does all prediction and comparison; this module only makes
// words, idles both sides and decides the outcome.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import c2s_pkg::*;

    // The closing wait covers the depth of the pipeline well.
    localparam int DrainCycles = 120;
    localparam int RandomWords = 1750;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    c2s_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    c2s_out_t out_data;
    int       errors;
    int       pending;
    // While set, neither side idles, so the pipeline runs at full rate.
    logic     busy_stretch;

    cartesian_to_spherical uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    c2s_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver stalls about a third of the time, except in the busy stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= busy_stretch ? 1'b0 : ($urandom_range(0, 99) < 34);
    end

    // Offers one word and holds it until the block takes it. Idle cycles are
    // inserted first, so gaps land at every phase of the pipeline.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        while (!busy_stretch && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data  <= '{coord_x: x, coord_y: y, coord_z: z};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Picks a coordinate: sometimes zero or an extreme, sometimes small,
    // mostly any value at all.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'(signed'($urandom_range(0, 64)) - 32);
            4:       return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        in_valid     = 1'b0;
        in_data      = '0;
        busy_stretch = 1'b0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: the origin, both halves of the z axis, points on the
        // x and y axes (the negative x axis wraps the azimuth to minus pi),
        // and the corners of the coordinate range.
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0, 32'h0, 32'h1);
        send_point(32'h0, 32'h0, 32'hFFFF_FFFF);
        send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
        send_point(32'h0, 32'h0, 32'h8000_0000);
        send_point(32'h1, 32'h0, 32'h0);
        send_point(32'hFFFF_FFFF, 32'h0, 32'h0);
        send_point(32'h0, 32'h1, 32'h0);
        send_point(32'h0, 32'hFFFF_FFFF, 32'h0);
        send_point(32'h8000_0000, 32'h0, 32'h0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h1, 32'h1, 32'h1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);
        send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);

        for (int n = 0; n < RandomWords; n++)
        begin
            busy_stretch = (n >= 600 && n < 900);
            // Midway the sender holds off until every result has come back.
            if (n == 1200)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_point(pick_coord(), pick_coord(), pick_coord());
        end
        in_valid     <= 1'b0;
        busy_stretch = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (errors == 0)
            $display("** cartesian_to_spherical: PASSED **");
        else
            $display("** cartesian_to_spherical: FAILED **");
        $finish;
    end

    // Far beyond the slowest correct run, stalls and idles included.
    initial
    begin
        #2ms;
        $display("** cartesian_to_spherical: FAILED **");
        $finish;
    end

endmodule
